// File: rtl/core/tsd_pkg.sv
package tsd_pkg;

  localparam int unsigned CoordW  = 16;
  localparam int unsigned ThreshW = 15;

  localparam logic [ThreshW-1:0] ThreshReset = 15'd30;

  typedef logic [CoordW-1:0] coord_t;

  typedef enum logic [2:0] {
    CODE_KEY_DOWN  = 3'd0,
    CODE_KEY_UP    = 3'd1,
    CODE_KEY_LEFT  = 3'd2,
    CODE_KEY_RIGHT = 3'd3,
    CODE_ABS_X     = 3'd4,
    CODE_ABS_Y     = 3'd5,
    CODE_TOUCH     = 3'd6,
    CODE_OTHER     = 3'd7
  } req_code_t;

  typedef enum logic [1:0] {
    GESTURE_NONE = 2'd0,
    GESTURE_DOWN = 2'd1,
    GESTURE_UP   = 2'd2
  } gesture_t;

endpackage

// File: rtl/core/tsd_swipe_eval.sv
module tsd_swipe_eval
  import tsd_pkg::*;
(
  input  coord_t             cur_x,
  input  coord_t             cur_y,
  input  coord_t             start_x,
  input  coord_t             start_y,
  input  logic [ThreshW-1:0] threshold,
  output logic               qualifies,
  output gesture_t           direction
);

  // The panel is mounted rotated, so the vertical motion comes from the
  // negated X travel and the horizontal motion from the negated Y travel.
  logic signed [CoordW-1:0] vdiff;
  logic signed [CoordW-1:0] hdiff;
  logic signed [CoordW-1:0] vmag;
  logic signed [CoordW-1:0] hmag;
  logic signed [CoordW-1:0] thresh_s;

  assign vdiff = signed'(start_x - cur_x);
  assign hdiff = signed'(start_y - cur_y);

  // Wrapping magnitude: the most negative value stays negative.
  assign vmag = vdiff[CoordW-1] ? -vdiff : vdiff;
  assign hmag = hdiff[CoordW-1] ? -hdiff : hdiff;

  assign thresh_s = signed'({1'b0, threshold});

  assign qualifies = (vmag > hmag) && (vmag > thresh_s);
  assign direction = (vdiff > 0) ? GESTURE_DOWN : GESTURE_UP;

endmodule

// File: rtl/core/touch_swipe_detector.sv
// Each result is registered and valid in the cycle after its input word is accepted.
// Throughput: one word per cycle; the result register is the only stage, and
// a new word is taken whenever that register is empty or being emptied.
// Reset (rst_n low, synchronous): coordinates, start point and touch state
// clear to zero, the swipe threshold returns to 30 and no result is held.
module touch_swipe_detector
  import tsd_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [ThreshW-1:0] cfg_swipe_threshold,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [2:0]         in_req_type,
  input  logic [15:0]        in_event_value,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         out_gesture,
  output logic               out_touch_report,
  output logic               out_touched,
  output logic [15:0]        out_point_x,
  output logic [15:0]        out_point_y
);

  logic [ThreshW-1:0] thresh_r;
  coord_t             cur_x_r, cur_x_nxt;
  coord_t             cur_y_r, cur_y_nxt;
  coord_t             start_x_r, start_x_nxt;
  coord_t             start_y_r, start_y_nxt;
  logic               pressed_r, pressed_nxt;
  logic               was_pressed_r, was_pressed_nxt;
  logic               armed_r, armed_nxt;
  logic               out_valid_r;
  gesture_t           gesture_r, gesture_nxt;
  logic               report_r, report_nxt;
  logic               touched_r;
  coord_t             point_x_r;
  coord_t             point_y_r;

  logic               accept;
  logic               swipe_ok;
  gesture_t           swipe_dir;
  req_code_t          code;
  logic               touch_now;

  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;
  assign code     = req_code_t'(in_req_type);
  assign touch_now = (in_event_value != '0);

  tsd_swipe_eval u_eval (
    .cur_x     (cur_x_r),
    .cur_y     (cur_y_r),
    .start_x   (start_x_r),
    .start_y   (start_y_r),
    .threshold (thresh_r),
    .qualifies (swipe_ok),
    .direction (swipe_dir)
  );

  always_comb begin
    cur_x_nxt       = cur_x_r;
    cur_y_nxt       = cur_y_r;
    start_x_nxt     = start_x_r;
    start_y_nxt     = start_y_r;
    pressed_nxt     = pressed_r;
    was_pressed_nxt = was_pressed_r;
    armed_nxt       = armed_r;
    gesture_nxt     = GESTURE_NONE;
    report_nxt      = 1'b0;
    unique case (code)
      CODE_KEY_DOWN: begin
        if (in_event_value == 16'd1) gesture_nxt = GESTURE_DOWN;
      end
      CODE_KEY_UP: begin
        if (in_event_value == 16'd1) gesture_nxt = GESTURE_UP;
      end
      CODE_ABS_X: cur_x_nxt = in_event_value;
      CODE_ABS_Y: cur_y_nxt = in_event_value;
      CODE_TOUCH: begin
        pressed_nxt     = touch_now;
        was_pressed_nxt = touch_now;
        report_nxt      = 1'b1;
        if (touch_now && !was_pressed_r) begin
          start_x_nxt = cur_x_r;
          start_y_nxt = cur_y_r;
          armed_nxt   = 1'b1;
        end else if (!touch_now && armed_r) begin
          if (swipe_ok) gesture_nxt = swipe_dir;
          armed_nxt = 1'b0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thresh_r      <= ThreshReset;
      cur_x_r       <= '0;
      cur_y_r       <= '0;
      start_x_r     <= '0;
      start_y_r     <= '0;
      pressed_r     <= 1'b0;
      was_pressed_r <= 1'b0;
      armed_r       <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      if (cfg_we) thresh_r <= cfg_swipe_threshold;
      if (accept) begin
        cur_x_r       <= cur_x_nxt;
        cur_y_r       <= cur_y_nxt;
        start_x_r     <= start_x_nxt;
        start_y_r     <= start_y_nxt;
        pressed_r     <= pressed_nxt;
        was_pressed_r <= was_pressed_nxt;
        armed_r       <= armed_nxt;
        out_valid_r   <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      gesture_r <= gesture_nxt;
      report_r  <= report_nxt;
      touched_r <= pressed_nxt;
      point_x_r <= cur_x_nxt;
      point_y_r <= cur_y_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_gesture      = gesture_r;
  assign out_touch_report = report_r;
  assign out_touched      = touched_r;
  assign out_point_x      = point_x_r;
  assign out_point_y      = point_y_r;

  // The previous-press flag follows every touch word, so it tracks the press state.
  a_press_track: assert property (@(posedge clk) disable iff (!rst_n)
    was_pressed_r == pressed_r)
    else $error("was_pressed diverged from pressed");

  // A swipe can only be armed while the panel is held.
  a_armed_held: assert property (@(posedge clk) disable iff (!rst_n)
    armed_r |-> pressed_r)
    else $error("swipe armed without a press");

  a_gesture_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (gesture_r != 2'd3))
    else $error("illegal gesture code");

  // A touch report always carries the press state of its own word.
  a_report_state: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && code == CODE_TOUCH) |=> (report_r && touched_r == pressed_r))
    else $error("touch report does not match press state");

  a_reset_empty: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_valid_r)
    else $error("result held after reset");

endmodule
